// ===== hdl/dtrd_pkg.sv =====
// types, constants and mode decode for the divider timer with reload delay
package dtrd_pkg;

  localparam int SUBTICKS_PER_TICK = 4;
  localparam int RELOAD_DELAY      = 4;

  localparam logic [15:0] DIV_RESET     = 16'h00AB;
  localparam logic [7:0]  CTRL_READ_SET = 8'hF8;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_CNT  = 2'd1;
  localparam logic [1:0] REG_MOD  = 2'd2;
  localparam logic [1:0] REG_CTRL = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] reg_sel;
    logic [7:0] write_data;
  } dtrd_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } dtrd_out_t;

  typedef struct packed {
    logic [15:0] divider;
    logic [7:0]  counter;
    logic [7:0]  modulo;
    logic [2:0]  control;
    logic [2:0]  reload_delay;
    logic        last_gate;
  } dtrd_state_t;

  // divider bit watched for each mode
  function automatic logic [3:0] mode_bit(input logic [1:0] mode);
    logic [3:0] idx;
    case (mode)
      2'd0:    idx = 4'd9;
      2'd1:    idx = 4'd3;
      2'd2:    idx = 4'd5;
      default: idx = 4'd7;
    endcase
    return idx;
  endfunction

endpackage

// ===== hdl/dtrd_step.sv =====
// next state and result for one transaction, ticks run all sub-cycles in a short chain
module dtrd_step
  import dtrd_pkg::*;
(
  input  dtrd_state_t state,
  input  dtrd_in_t    req,
  output dtrd_state_t state_next,
  output dtrd_out_t   result
);

  always_comb begin
    dtrd_state_t st;
    logic        gate;
    logic        irq;
    logic [7:0]  rd;
    st   = state;
    irq  = 1'b0;
    rd   = 8'h00;
    gate = 1'b0;
    unique case (req.req_type)
      REQ_TICK: begin
        for (int i = 0; i < SUBTICKS_PER_TICK; i++) begin
          st.divider = st.divider + 16'd1;
          if (st.reload_delay != 3'd0) begin
            st.reload_delay = st.reload_delay - 3'd1;
            if (st.reload_delay == 3'd0) begin
              st.counter = st.modulo;
              irq        = 1'b1;
            end
          end
          gate = st.divider[mode_bit(st.control[1:0])] & st.control[2];
          // falling edge of the gated divider bit
          if (st.last_gate && !gate) begin
            st.counter = st.counter + 8'd1;
            if (st.counter == 8'h00) begin
              st.reload_delay = 3'(RELOAD_DELAY);
            end
          end
          st.last_gate = gate;
        end
      end
      REQ_READ: begin
        unique case (req.reg_sel)
          REG_DIV:  rd = st.divider[15:8];
          REG_CNT:  rd = st.counter;
          REG_MOD:  rd = st.modulo;
          REG_CTRL: rd = {5'b0, st.control} | CTRL_READ_SET;
          default:  rd = 8'h00;
        endcase
      end
      REQ_WRITE: begin
        unique case (req.reg_sel)
          REG_DIV: st.divider = 16'h0000;
          REG_CNT: begin
            st.counter      = req.write_data;
            st.reload_delay = 3'd0;
          end
          REG_MOD:  st.modulo  = req.write_data;
          REG_CTRL: st.control = req.write_data[2:0];
          default:  st.modulo  = st.modulo;
        endcase
      end
      default: st = state;
    endcase
    state_next       = st;
    result.read_data = rd;
    result.timer_irq = irq;
  end

endmodule

// ===== hdl/dtrd_out_reg.sv =====
// result register between the step logic and the output channel
module dtrd_out_reg
  import dtrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  dtrd_out_t load_data,
  output logic      full,
  input  logic      out_stall,
  output logic      out_valid,
  output dtrd_out_t out_data
);

  assign full = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== hdl/divider_timer_with_reload_delay_core.sv =====
// top level of the divider timer with delayed counter reload
//
//   channel  direction  payload     handshake
//   in       to block   dtrd_in_t   in_valid / in_stall
//   out      from block dtrd_out_t  out_valid / out_stall
//
// one transaction per cycle while in_stall is low; its result is on out in the cycle after acceptance
// a tick runs all sub-cycles through one chain of logic ahead of the result register
// rst clears the timer state (divider to 0x00AB) and empties the result register
// in_stall is high only while a result waits and out_stall is high
module divider_timer_with_reload_delay_core
  import dtrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dtrd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output dtrd_out_t out_data
);

  dtrd_state_t state;
  dtrd_state_t state_next;
  dtrd_out_t   result;
  logic        accept;

  assign accept = in_valid & ~in_stall;

  dtrd_step u_step (
    .state      (state),
    .req        (in_data),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.divider      <= DIV_RESET;
      state.counter      <= 8'h00;
      state.modulo       <= 8'h00;
      state.control      <= 3'd0;
      state.reload_delay <= 3'd0;
      state.last_gate    <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  dtrd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_data (result),
    .full      (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction left no result");

  a_irq_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.req_type != REQ_TICK) |=> !out_data.timer_irq)
    else $error("timer_irq raised by a bus access");

  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.req_type != REQ_READ) |=> out_data.read_data == 8'h00)
    else $error("read_data nonzero on a non-read transaction");

  a_delay_bound: assert property (@(posedge clk) disable iff (rst)
    state.reload_delay <= 3'(RELOAD_DELAY))
    else $error("reload delay out of range");
`endif

endmodule
